>>> sv/sita_pkg.sv
// Shared types, widths and arithmetic helpers for the inertia tensor accumulator.
package sita_pkg;

	localparam int COORD_BITS = 12;
	localparam int FRAC_BITS  = 8;

	localparam int CENTER_W = COORD_BITS + FRAC_BITS;
	localparam int OFFS_W   = CENTER_W + 1;
	localparam int PROD_W   = 2 * OFFS_W;
	localparam int SUM_W    = 64;
	localparam int DIAG_W   = SUM_W - 1;

	localparam int IN_FIELDS_W = 3 * COORD_BITS + 3 * CENTER_W;
	localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = 3 * DIAG_W + 3 * SUM_W;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

	typedef logic [COORD_BITS-1:0]   coord_t;
	typedef logic [CENTER_W-1:0]     center_t;
	typedef logic signed [OFFS_W-1:0] offs_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [SUM_W-1:0]  sum_t;
	typedef logic [DIAG_W-1:0]        diag_t;

	localparam sum_t SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam sum_t SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	typedef struct packed {
		prod_t sq_x;
		prod_t sq_y;
		prod_t sq_z;
		prod_t cr_xy;
		prod_t cr_xz;
		prod_t cr_yz;
	} prods_t;

	typedef struct packed {
		sum_t sq_x;
		sum_t sq_y;
		sum_t sq_z;
		sum_t cr_xy;
		sum_t cr_xz;
		sum_t cr_yz;
	} sums_t;

	typedef struct packed {
		diag_t xx;
		diag_t yy;
		diag_t zz;
		sum_t  xy;
		sum_t  xz;
		sum_t  yz;
	} tensor_t;

	// accumulator control: one transaction leaving the product stage
	typedef struct packed {
		logic go;
		logic present;
		logic last;
	} acc_ctl_t;

	// voxel * 2^FRAC_BITS - center, signed
	function automatic offs_t offset_of(coord_t v, center_t c);
		offs_t vs;
		offs_t cs;
		vs = offs_t'(v) << FRAC_BITS;
		cs = offs_t'(c);
		return vs - cs;
	endfunction

	function automatic sum_t sat_add(sum_t a, prod_t b);
		logic signed [SUM_W:0] s;
		s = {a[SUM_W-1], a} + (SUM_W+1)'(b);
		if (s[SUM_W] != s[SUM_W-1])
			return s[SUM_W] ? SUM_MIN : SUM_MAX;
		return s[SUM_W-1:0];
	endfunction

	// both operands are non-negative
	function automatic diag_t diag_of(sum_t a, sum_t b);
		logic [SUM_W-1:0] s;
		s = SUM_W'(unsigned'(a)) + SUM_W'(unsigned'(b));
		return s[SUM_W-1] ? {DIAG_W{1'b1}} : s[DIAG_W-1:0];
	endfunction

	function automatic sum_t neg_of(sum_t a);
		return (a == SUM_MIN) ? SUM_MAX : -a;
	endfunction

endpackage

>>> sv/sita_product.sv
// Per-axis offsets from the center and the six offset products.
module sita_product (
	input  sita_pkg::coord_t  voxel_x,
	input  sita_pkg::coord_t  voxel_y,
	input  sita_pkg::coord_t  voxel_z,
	input  sita_pkg::center_t center_x,
	input  sita_pkg::center_t center_y,
	input  sita_pkg::center_t center_z,
	output sita_pkg::prods_t  prod
);
	import sita_pkg::*;

	offs_t dx;
	offs_t dy;
	offs_t dz;

	assign dx = offset_of(voxel_x, center_x);
	assign dy = offset_of(voxel_y, center_y);
	assign dz = offset_of(voxel_z, center_z);

	always_comb begin
		prod.sq_x  = prod_t'(dx) * prod_t'(dx);
		prod.sq_y  = prod_t'(dy) * prod_t'(dy);
		prod.sq_z  = prod_t'(dz) * prod_t'(dz);
		prod.cr_xy = prod_t'(dx) * prod_t'(dy);
		prod.cr_xz = prod_t'(dx) * prod_t'(dz);
		prod.cr_yz = prod_t'(dy) * prod_t'(dz);
	end

endmodule

>>> sv/sita_accum.sv
// Six saturating running sums, cleared after the last voxel of a segment.
module sita_accum (
	input  logic             clk,
	input  logic             arst_n,
	input  sita_pkg::acc_ctl_t ctl,
	input  sita_pkg::prods_t prod,
	output sita_pkg::sums_t  sums_next
);
	import sita_pkg::*;

	sums_t sums_q;
	sums_t sums_add;

	always_comb begin
		sums_add.sq_x  = sat_add(sums_q.sq_x,  prod.sq_x);
		sums_add.sq_y  = sat_add(sums_q.sq_y,  prod.sq_y);
		sums_add.sq_z  = sat_add(sums_q.sq_z,  prod.sq_z);
		sums_add.cr_xy = sat_add(sums_q.cr_xy, prod.cr_xy);
		sums_add.cr_xz = sat_add(sums_q.cr_xz, prod.cr_xz);
		sums_add.cr_yz = sat_add(sums_q.cr_yz, prod.cr_yz);
		sums_next = ctl.present ? sums_add : sums_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sums_q <= '0;
		end else if (ctl.go) begin
			if (ctl.last)
				sums_q <= '0;
			else
				sums_q <= sums_next;
		end
	end

endmodule

>>> sv/sita_tensor.sv
// Tensor entries from final sums: diagonal pair sums and negated cross sums.
module sita_tensor (
	input  sita_pkg::sums_t   sums,
	output sita_pkg::tensor_t tensor
);
	import sita_pkg::*;

	always_comb begin
		tensor.xx = diag_of(sums.sq_y, sums.sq_z);
		tensor.yy = diag_of(sums.sq_x, sums.sq_z);
		tensor.zz = diag_of(sums.sq_x, sums.sq_y);
		tensor.xy = neg_of(sums.cr_xy);
		tensor.xz = neg_of(sums.cr_xz);
		tensor.yz = neg_of(sums.cr_yz);
	end

endmodule

>>> sv/segment_inertia_tensor_accumulator.sv
// Top level of the segment inertia tensor accumulator.
// One voxel transaction per cycle enters on the slave side while s_tready is
// high and flows through four registered steps: input register (_s1), offset
// products (_s2), the running sums with their segment-final snapshot (_s3),
// and the output register holding the tensor. A segment's last transaction
// passes through _s1 and _s2, and its sums through _s3 into the output register.
// Each step holds its own valid bit and only waits when the step after it is
// full, so input keeps flowing while a finished tensor waits on m_tready; only
// segment-closing transactions need room in the snapshot register.
// tuser = voxel_present: when low, nothing is added, and with tlast high it
// simply closes the segment (empty segment gives all zeros). Sums are signed
// 64 bit, saturating, with 2*FRAC_BITS fraction bits.
module segment_inertia_tensor_accumulator (
	input  logic clk,
	input  logic arst_n,
	// slave side
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [11:0] voxel_x, [23:12] voxel_y, [35:24] voxel_z,
	// [55:36] center_x, [75:56] center_y, [95:76] center_z
	input  logic [sita_pkg::IN_TDATA_W-1:0] s_tdata,
	input  logic                            s_tuser,   // [0] voxel_present
	input  logic                            s_tlast,   // segment_last
	// master side
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [62:0] tensor_xx, [125:63] tensor_yy, [188:126] tensor_zz,
	// [252:189] tensor_xy, [316:253] tensor_xz, [380:317] tensor_yz, rest zero
	output logic [sita_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import sita_pkg::*;

	localparam int VY_LO = COORD_BITS;
	localparam int VZ_LO = 2 * COORD_BITS;
	localparam int CX_LO = 3 * COORD_BITS;
	localparam int CY_LO = CX_LO + CENTER_W;
	localparam int CZ_LO = CY_LO + CENTER_W;

	// step valids
	logic v_s1, v_s2, v_s3, out_valid_q;
	// step movement
	logic out_free, s3_free, s2_go, s2_free, s1_go, s1_free;

	// input register
	logic    present_s1, last_s1;
	coord_t  vx_s1, vy_s1, vz_s1;
	center_t cx_s1, cy_s1, cz_s1;

	// products
	prods_t  prod_comb;
	prods_t  prod_s2;
	logic    present_s2, last_s2;

	acc_ctl_t acc_ctl;
	sums_t    sums_next;
	sums_t    sums_s3;
	tensor_t  tensor_comb;
	tensor_t  tensor_q;

	// backpressure chain: a step loads when empty or when it moves on
	assign out_free = !out_valid_q || m_tready;
	assign s3_free  = !v_s3 || out_free;
	assign s2_go    = v_s2 && (!last_s2 || s3_free);
	assign s2_free  = !v_s2 || s2_go;
	assign s1_go    = v_s1 && s2_free;
	assign s1_free  = !v_s1 || s1_go;
	assign s_tready = s1_free;

	sita_product u_product (
		.voxel_x  (vx_s1),
		.voxel_y  (vy_s1),
		.voxel_z  (vz_s1),
		.center_x (cx_s1),
		.center_y (cy_s1),
		.center_z (cz_s1),
		.prod     (prod_comb)
	);

	assign acc_ctl.go      = s2_go;
	assign acc_ctl.present = present_s2;
	assign acc_ctl.last    = last_s2;

	sita_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (acc_ctl),
		.prod      (prod_s2),
		.sums_next (sums_next)
	);

	sita_tensor u_tensor (
		.sums   (sums_s3),
		.tensor (tensor_comb)
	);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_free)
				v_s1 <= s_tvalid;
			if (s2_free)
				v_s2 <= v_s1;
			if (s3_free)
				v_s3 <= s2_go && last_s2;
			if (out_free)
				out_valid_q <= v_s3;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (s1_free && s_tvalid) begin
			present_s1 <= s_tuser;
			last_s1    <= s_tlast;
			vx_s1      <= s_tdata[COORD_BITS-1:0];
			vy_s1      <= s_tdata[VY_LO +: COORD_BITS];
			vz_s1      <= s_tdata[VZ_LO +: COORD_BITS];
			cx_s1      <= s_tdata[CX_LO +: CENTER_W];
			cy_s1      <= s_tdata[CY_LO +: CENTER_W];
			cz_s1      <= s_tdata[CZ_LO +: CENTER_W];
		end
		if (s1_go) begin
			prod_s2    <= prod_comb;
			present_s2 <= present_s1;
			last_s2    <= last_s1;
		end
		if (s3_free && s2_go && last_s2)
			sums_s3 <= sums_next;
		if (out_free && v_s3)
			tensor_q <= tensor_comb;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_TDATA_W'({tensor_q.yz, tensor_q.xz, tensor_q.xy,
		tensor_q.zz, tensor_q.yy, tensor_q.xx});

endmodule
